@@ rtl/core/rmbt_pkg.sv @@
// Shared types and constants for the run merge block tiler.
package rmbt_pkg;

    localparam int MAX_BLOCKS = 31;
    localparam int NB_W       = $clog2(MAX_BLOCKS + 1);
    // block start can pass lda by up to one block
    localparam int BS_W       = 18;

    localparam logic [1:0] KIND_PIECE = 2'd0;
    localparam logic [1:0] KIND_MARK  = 2'd1;
    localparam logic [1:0] KIND_ERR   = 2'd2;

    localparam logic CFG_LDA   = 1'b0;
    localparam logic CFG_BSIZE = 1'b1;

    localparam logic [16:0] LDA_RST   = 17'd65536;
    localparam logic [16:0] BSIZE_RST = 17'd2048;

    typedef struct packed {
        logic [13:0] shell_index;
        logic [15:0] ao_begin;
        logic [16:0] ao_end;
        logic        last;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] big_start;
        logic [16:0] length;
        logic [16:0] small_start;
        logic [15:0] piece_count;
        logic        final_res;
    } t_out_word;

    typedef struct packed {
        logic accept;
        logic step;
        logic sel_run;
        logic flush;
        logic drain;
        logic clear;
    } t_dp_cmd;

    typedef struct packed {
        logic needs_close;
        logic step_last;
        logic hold_valid;
        logic out_free;
    } t_dp_status;

endpackage

@@ rtl/core/run_merge_block_tiler_unit.sv @@
// Run merge block tiler: top level joining sequencer and datapath.
// A word that only extends or opens a run leaves the block idle; such words can follow
// every cycle. A word that closes a run stalls input while its results are stepped out,
// with a step without result if the close stops on the block limit; output stalls add.
// Results move from hold slot to output register on the next result or on the drain.
// Reset: synchronous, active low; clears stream state, lda to 65536, block size to 2048.
module run_merge_block_tiler_unit import rmbt_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [16:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_word    i_in_word,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_word   o_out_word
);

    t_dp_cmd    cmd;
    t_dp_status status;
    logic       idle;

    assign o_in_stall = !idle;

    rmbt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_last  (i_in_word.last),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_idle     (idle)
    );

    rmbt_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_word   (i_in_word),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

    a_hold_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.hold_valid |-> o_in_stall)
        else $error("word held while input open");

    a_step_not_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.step |-> !cmd.accept)
        else $error("step while accepting");

    a_kind_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_word.kind == KIND_PIECE || o_out_word.kind == KIND_MARK
                         || o_out_word.kind == KIND_ERR))
        else $error("illegal result kind");

    a_marker_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.kind == KIND_MARK)
            |-> (o_out_word.length == 17'd0 && o_out_word.small_start == 17'd0))
        else $error("marker carries piece data");

endmodule

@@ rtl/core/rmbt_ctrl.sv @@
// Sequencer: accepts words and walks the close, flush and drain phases.
module rmbt_ctrl import rmbt_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_last,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd,
    output logic       o_idle
);

    typedef enum logic [4:0] {
        S_IDLE    = 5'b00001,
        S_CLOSE_A = 5'b00010,
        S_CLOSE_B = 5'b00100,
        S_FLUSH   = 5'b01000,
        S_DRAIN   = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic   r_fin, n_fin;
    logic   stepping;
    logic   step_phase;

    assign o_idle     = (r_state == S_IDLE);
    assign step_phase = (r_state == S_CLOSE_A) || (r_state == S_CLOSE_B)
                     || (r_state == S_FLUSH);
    // at most one result per step; hold slot must be able to spill first
    assign stepping   = step_phase && (!i_status.hold_valid || i_status.out_free);

    always_comb begin
        n_state = r_state;
        n_fin   = r_fin;
        o_cmd   = '0;
        o_cmd.step    = stepping;
        o_cmd.sel_run = (r_state == S_CLOSE_B);
        o_cmd.flush   = (r_state == S_FLUSH);
        case (r_state)
            S_IDLE: begin
                o_cmd.accept = i_in_valid;
                if (i_in_valid) begin
                    n_fin = i_in_last;
                    if (i_status.needs_close) begin
                        n_state = S_CLOSE_A;
                    end else if (i_in_last) begin
                        n_state = S_CLOSE_B;
                    end
                end
            end
            S_CLOSE_A: begin
                if (stepping && i_status.step_last) begin
                    n_state = r_fin ? S_CLOSE_B : S_DRAIN;
                end
            end
            S_CLOSE_B: begin
                if (stepping && i_status.step_last) begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                if (stepping && i_status.step_last) begin
                    o_cmd.clear = 1'b1;
                    n_state     = S_DRAIN;
                end
            end
            S_DRAIN: begin
                o_cmd.drain = i_status.hold_valid && i_status.out_free;
                if (!i_status.hold_valid || i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fin   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fin   <= n_fin;
        end
    end

endmodule

@@ rtl/core/rmbt_dpath.sv @@
// Datapath: run merge registers, block tiling step, hold slot and output register.
module rmbt_dpath import rmbt_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [16:0] i_cfg_data,
    input  t_in_word    i_in_word,
    input  t_dp_cmd     i_cmd,
    output t_dp_status  o_status,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_word   o_out_word
);

    logic [16:0]     r_lda, r_bsize;
    logic [15:0]     r_run_begin;
    logic [16:0]     r_run_end;
    logic [13:0]     r_prev_shell;
    logic            r_run_open;
    logic [15:0]     r_lo;
    logic [16:0]     r_hi;
    logic [BS_W-1:0] r_block_start;
    logic [NB_W-1:0] r_block_num;
    logic [16:0]     r_packed;
    logic [15:0]     r_pieces;
    logic            r_eb_pend;
    logic            r_hold_valid;
    t_out_word       r_hold;
    logic            r_out_valid;
    t_out_word       r_out;

    logic            follows;
    logic [15:0]     lo;
    logic [16:0]     hi;
    logic [BS_W-1:0] lo_x, hi_x, top;
    logic            blocks_done;
    logic            res_v, is_piece, end_blk, pend_set, step_last;
    t_out_word       res;
    t_out_word       hold_last;
    logic            out_free;

    assign follows = r_run_open
        && ({1'b0, i_in_word.shell_index} == ({1'b0, r_prev_shell} + 15'd1));
    assign out_free = !r_out_valid || !i_out_stall;

    assign lo   = i_cmd.sel_run ? r_run_begin : r_lo;
    assign hi   = i_cmd.sel_run ? r_run_end : r_hi;
    assign lo_x = {2'b00, lo};
    assign hi_x = {1'b0, hi};
    assign top  = r_block_start + {1'b0, r_bsize};
    assign blocks_done = (r_block_num >= NB_W'(MAX_BLOCKS))
                      || (r_block_start >= {1'b0, r_lda});

    // one tiling step: at most one word out
    always_comb begin
        logic [BS_W-1:0] diff;
        diff      = '0;
        res_v     = 1'b0;
        is_piece  = 1'b0;
        end_blk   = 1'b0;
        pend_set  = 1'b0;
        step_last = 1'b0;
        res       = '0;
        if (r_eb_pend) begin
            res_v   = 1'b1;
            end_blk = 1'b1;
        end else if (blocks_done) begin
            step_last = 1'b1;
        end else if (i_cmd.flush || lo_x >= top) begin
            res_v   = 1'b1;
            end_blk = 1'b1;
        end else if (lo_x < r_block_start && hi_x < r_block_start) begin
            res_v         = 1'b1;
            step_last     = 1'b1;
            res.kind      = KIND_ERR;
            res.big_start = lo;
            res.length    = hi;
        end else begin
            res_v    = 1'b1;
            is_piece = 1'b1;
            if (lo_x < r_block_start) begin
                res.big_start = r_block_start[15:0];
                if (hi_x > top) begin
                    diff     = {1'b0, r_bsize};
                    pend_set = 1'b1;
                end else begin
                    diff      = hi_x - r_block_start;
                    step_last = 1'b1;
                end
            end else begin
                res.big_start = lo;
                if (hi_x > top) begin
                    diff     = top - lo_x;
                    pend_set = 1'b1;
                end else begin
                    diff      = hi_x - lo_x;
                    step_last = 1'b1;
                end
            end
            res.length      = diff[16:0];
            res.small_start = r_packed;
        end
        if (res_v && !is_piece && res.kind != KIND_ERR) begin
            res.kind        = KIND_MARK;
            res.piece_count = r_pieces;
        end
    end

    assign o_status.needs_close = r_run_open && !follows;
    assign o_status.step_last   = step_last;
    assign o_status.hold_valid  = r_hold_valid;
    assign o_status.out_free    = out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lda   <= LDA_RST;
            r_bsize <= BSIZE_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_LDA) begin
                r_lda <= i_cfg_data;
            end
            if (i_cfg_index == CFG_BSIZE) begin
                r_bsize <= i_cfg_data;
            end
        end
    end

    // stream state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_run_begin   <= '0;
            r_run_end     <= '0;
            r_prev_shell  <= '0;
            r_run_open    <= 1'b0;
            r_block_start <= '0;
            r_block_num   <= '0;
            r_packed      <= '0;
            r_pieces      <= '0;
            r_eb_pend     <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                r_prev_shell <= i_in_word.shell_index;
                if (follows) begin
                    r_run_end <= i_in_word.ao_end;
                end else begin
                    r_run_begin <= i_in_word.ao_begin;
                    r_run_end   <= i_in_word.ao_end;
                    r_run_open  <= 1'b1;
                end
            end
            if (i_cmd.step) begin
                r_eb_pend <= pend_set;
                if (is_piece) begin
                    r_packed <= r_packed + res.length;
                    r_pieces <= r_pieces + 16'd1;
                end
                if (end_blk) begin
                    r_block_start <= r_block_start + {1'b0, r_bsize};
                    r_block_num   <= r_block_num + NB_W'(1);
                end
            end
        end
    end

    // operands of the run being closed
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && !follows) begin
            r_lo <= r_run_begin;
            r_hi <= r_run_end;
        end
    end

    // held word goes out flagged as the last of its input
    always_comb begin
        hold_last           = r_hold;
        hold_last.final_res = 1'b1;
    end

    // hold slot keeps each word until the next one arrives so the last one can be flagged
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else if (i_cmd.drain) begin
            r_hold_valid <= 1'b0;
            r_out_valid  <= 1'b1;
        end else if (i_cmd.step && res_v) begin
            r_hold_valid <= 1'b1;
            if (r_hold_valid) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.drain) begin
            r_out <= hold_last;
        end else if (i_cmd.step && res_v) begin
            r_hold <= res;
            if (r_hold_valid) begin
                r_out <= r_hold;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule

@@ verif/tb_run_merge_block_tiler_unit.sv @@
// Testbench for the run merge block tiler: directed table, then randomized shell lists.
`timescale 1ns / 100ps

module tb_run_merge_block_tiler_unit;
    import rmbt_pkg::*;

    localparam int LIMIT_CYCLES = 500000;
    localparam int SETTLE_CYCLES = 200;
    localparam int MAX_WORDS_OUT = 64;
    localparam int N_PLAN = 15;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_index = CFG_LDA;
    logic [16:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    t_in_word    i_in_word = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out_word   o_out_word;

    run_merge_block_tiler_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ---------------- tiling predictor ----------------
    int unsigned lda_r = 65536;
    int unsigned bsize_r = 2048;
    int unsigned run_lo, run_hi, prev_sh, blk_start, packed_pos, npieces, nblocks;
    bit          run_open_r;

    t_out_word tile_out[$];    // words produced by the current shell
    t_out_word tiles_due[$];   // words still to come out of the block

    int send_idle_pct = 9;
    int recv_idle_pct = 77;
    int mismatches = 0;
    int cycles = 0;

    function automatic void clear_stream();
        run_lo = 0;
        run_hi = 0;
        prev_sh = 0;
        run_open_r = 1'b0;
        blk_start = 0;
        packed_pos = 0;
        npieces = 0;
        nblocks = 0;
    endfunction

    function automatic t_out_word tile(logic [1:0] k, int unsigned big, int unsigned len,
                                       int unsigned sml, int unsigned cnt, bit fin);
        t_out_word o;
        o.kind        = k;
        o.big_start   = 16'(big);
        o.length      = 17'(len);
        o.small_start = 17'(sml);
        o.piece_count = 16'(cnt);
        o.final_res   = fin;
        return o;
    endfunction

    function automatic void emit(logic [1:0] k, int unsigned big, int unsigned len,
                                 int unsigned sml, int unsigned cnt);
        if (tile_out.size() >= MAX_WORDS_OUT) return;
        tile_out.insert(tile_out.size(), tile(k, big, len, sml, cnt, 1'b0));
    endfunction

    function automatic bit tiling_over();
        return nblocks >= MAX_BLOCKS || blk_start >= lda_r;
    endfunction

    function automatic void close_block();
        emit(KIND_MARK, 0, 0, 0, npieces);
        blk_start = blk_start + bsize_r;
        nblocks = nblocks + 1;
    endfunction

    function automatic void add_piece(int unsigned big, int unsigned len);
        int unsigned l;
        l = len & 32'h1ffff;
        emit(KIND_PIECE, big, l, packed_pos, 0);
        packed_pos = (packed_pos + l) & 32'h1ffff;
        npieces = (npieces + 1) & 32'hffff;
    endfunction

    function automatic void close_run(int unsigned lo, int unsigned hi);
        int unsigned top;
        while (!tiling_over()) begin
            top = blk_start + bsize_r;
            if (lo >= top) begin
                close_block();
            end else if (lo < blk_start && hi < blk_start) begin
                emit(KIND_ERR, lo, hi, 0, 0);
                return;
            end else if (lo < blk_start && hi > top) begin
                add_piece(blk_start, top - blk_start);
                close_block();
            end else if (lo < blk_start) begin
                add_piece(blk_start, hi - blk_start);
                return;
            end else if (hi > top) begin
                add_piece(lo, top - lo);
                close_block();
            end else begin
                add_piece(lo, hi - lo);
                return;
            end
        end
    endfunction

    function automatic void tile_shell(t_in_word w);
        int unsigned sh, ab, ae;
        tile_out.delete();
        sh = w.shell_index;
        ab = w.ao_begin;
        ae = w.ao_end;
        if (run_open_r && sh == prev_sh + 1) begin
            run_hi = ae;
        end else begin
            if (run_open_r) close_run(run_lo, run_hi);
            run_lo = ab;
            run_hi = ae;
            run_open_r = 1'b1;
        end
        prev_sh = sh;
        if (w.last) begin
            close_run(run_lo, run_hi);
            while (!tiling_over()) close_block();
            clear_stream();
        end
        if (tile_out.size() > 0) tile_out[tile_out.size() - 1].final_res = 1'b1;
    endfunction

    // ---------------- drivers ----------------
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d words outstanding", cycles, tiles_due.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // returns once the word is accepted
    task automatic send_shell(input t_in_word w);
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        tile_shell(w);
    endtask

    task automatic wait_drain();
        do @(posedge i_clk); while (tiles_due.size() > 0);
    endtask

    task automatic write_cfg(input int unsigned lda_v, input int unsigned bs_v);
        i_in_valid <= 1'b0;
        wait_drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_LDA;
        i_cfg_data  <= 17'(lda_v);
        @(posedge i_clk);
        i_cfg_index <= CFG_BSIZE;
        i_cfg_data  <= 17'(bs_v);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        lda_r   = lda_v & 32'h1ffff;
        bsize_r = bs_v & 32'h1ffff;
    endtask

    // ---------------- result checker ----------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (tiles_due.size() == 0) begin
                mismatches <= mismatches + 1;
                if (mismatches < 10)
                    $display("unexpected word: kind %0d big %0d len %0d small %0d cnt %0d fin %0d",
                             o_out_word.kind, o_out_word.big_start, o_out_word.length,
                             o_out_word.small_start, o_out_word.piece_count,
                             o_out_word.final_res);
            end else begin
                if (o_out_word.kind != tiles_due[0].kind ||
                    o_out_word.big_start != tiles_due[0].big_start ||
                    o_out_word.length != tiles_due[0].length ||
                    o_out_word.small_start != tiles_due[0].small_start ||
                    o_out_word.piece_count != tiles_due[0].piece_count ||
                    o_out_word.final_res != tiles_due[0].final_res) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10) begin
                        $display("mismatch: exp kind %0d big %0d len %0d small %0d cnt %0d fin %0d",
                                 tiles_due[0].kind, tiles_due[0].big_start, tiles_due[0].length,
                                 tiles_due[0].small_start, tiles_due[0].piece_count,
                                 tiles_due[0].final_res);
                        $display("          got kind %0d big %0d len %0d small %0d cnt %0d fin %0d",
                                 o_out_word.kind, o_out_word.big_start, o_out_word.length,
                                 o_out_word.small_start, o_out_word.piece_count,
                                 o_out_word.final_res);
                    end
                end
                void'(tiles_due.pop_front());
            end
        end
    end

    // ---------------- stimulus ----------------
    typedef struct packed {
        t_in_word  w;
        logic      typed;    // expectation written in the row
        logic      has_res;  // typed row yields one word
        t_out_word res;
    } t_plan_row;

    t_plan_row plan [N_PLAN];

    function automatic t_in_word shell(int unsigned sh, int unsigned ab, int unsigned ae, bit l);
        t_in_word w;
        w.shell_index = 14'(sh);
        w.ao_begin    = 16'(ab);
        w.ao_end      = 17'(ae);
        w.last        = l;
        return w;
    endfunction

    task automatic run_phase(input int unsigned lda_v, input int unsigned bs_v, input int n_words);
        int          sent, len, k, r;
        int unsigned scale, sh, cursor, lo, hi;
        t_in_word    w;
        write_cfg(lda_v, bs_v);
        scale = (bsize_r == 0) ? 64 : bsize_r;
        if (lda_r != 0 && scale > lda_r) scale = lda_r;
        sent = 0;
        while (sent < n_words) begin
            len = $urandom_range(1, 10);
            sh = $urandom_range(0, 16383);
            cursor = $urandom_range(0, scale);
            for (k = 0; k < len; k++) begin
                r = $urandom_range(99);
                if (k > 0 && r < 70) begin
                    sh = sh + 1;
                    lo = cursor;
                end else if (k > 0 && r < 90) begin
                    sh = sh + $urandom_range(2, 4);
                    lo = cursor + $urandom_range(0, scale);
                end else if (k > 0) begin
                    // out-of-order shell, range moving backwards
                    sh = $urandom_range(0, 16383);
                    lo = $urandom_range(0, cursor);
                end else begin
                    lo = cursor;
                end
                if ($urandom_range(99) < 5)
                    hi = (lo > 0) ? $urandom_range(0, lo - 1) : 0;
                else
                    hi = lo + $urandom_range(0, 2 * scale);
                if (lo > 65535) lo = 65535;
                if (hi > 65536) hi = 65536;
                cursor = (hi > lo) ? hi : lo;
                w = shell(sh, lo, hi, k == len - 1);
                if ($urandom_range(99) < 10) begin
                    w.shell_index = 14'($urandom);
                    w.ao_begin    = 16'($urandom);
                    w.ao_end      = 17'($urandom);
                    w.last        = (k == len - 1) || ($urandom_range(7) == 0);
                end
                if ($urandom_range(99) < 3) begin
                    i_in_valid <= 1'b0;
                    wait_drain();
                end
                send_shell(w);
                foreach (tile_out[j]) tiles_due.insert(tiles_due.size(), tile_out[j]);
                sent++;
            end
        end
    endtask

    initial begin
        int i;
        clear_stream();
        plan[0]  = '{shell(0, 0, 10, 0), 1'b1, 1'b0, '0};
        plan[1]  = '{shell(1, 10, 20, 0), 1'b1, 1'b0, '0};
        plan[2]  = '{shell(5, 100, 200, 0), 1'b1, 1'b1, tile(KIND_PIECE, 0, 20, 0, 0, 1)};
        plan[3]  = '{shell(6, 200, 2100, 0), 1'b1, 1'b0, '0};
        plan[4]  = '{shell(9, 3000, 3100, 0), 1'b0, 1'b0, '0};
        // run that ends exactly on the block start
        plan[5]  = '{shell(11, 1000, 2048, 0), 1'b0, 1'b0, '0};
        plan[6]  = '{shell(13, 100, 200, 0), 1'b0, 1'b0, '0};
        // run wholly before the current block
        plan[7]  = '{shell(15, 5000, 4000, 0), 1'b1, 1'b1, tile(KIND_ERR, 100, 200, 0, 0, 1)};
        // reversed range closes here, shell index wraps next
        plan[8]  = '{shell(16383, 65535, 65536, 0), 1'b0, 1'b0, '0};
        plan[9]  = '{shell(0, 0, 65536, 1), 1'b0, 1'b0, '0};
        plan[10] = '{shell(100, 0, 65536, 1), 1'b0, 1'b0, '0};
        plan[11] = '{shell(16383, 65535, 65535, 1), 1'b0, 1'b0, '0};
        plan[12] = '{shell(0, 0, 0, 1), 1'b0, 1'b0, '0};
        plan[13] = '{shell(20, 50, 60, 0), 1'b1, 1'b0, '0};
        plan[14] = '{shell(21, 60, 70, 1), 1'b0, 1'b0, '0};

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (i = 0; i < N_PLAN; i++) begin
            send_shell(plan[i].w);
            if (plan[i].typed) begin
                if (plan[i].has_res) tiles_due.insert(tiles_due.size(), plan[i].res);
            end else begin
                foreach (tile_out[j]) tiles_due.insert(tiles_due.size(), tile_out[j]);
            end
        end

        run_phase(65536, 2048, 28);
        run_phase(1, 1, 28);
        send_idle_pct = 77;
        recv_idle_pct = 9;
        run_phase(65536, 65536, 28);
        run_phase(0, 4096, 28);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_phase(20000, 0, 28);
        run_phase($urandom_range(1, 65536), $urandom_range(1, 4096), 28);
        run_phase(131071, 65536, 28);

        i_in_valid <= 1'b0;
        wait_drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (tiles_due.size() > 0) $display("%0d expected words never came", tiles_due.size());
        if (mismatches == 0 && tiles_due.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/rmbt_pkg.sv
rtl/core/rmbt_ctrl.sv
rtl/core/rmbt_dpath.sv
rtl/core/run_merge_block_tiler_unit.sv
verif/tb_run_merge_block_tiler_unit.sv
